@@ sv/plr_pkg.sv @@
package plr_pkg;

	// Default widths of a coordinate and of a color value
	localparam int COORD_BITS_DEF = 12;
	localparam int COLOR_BITS_DEF = 8;

	// Operation codes of an input word
	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ADVANCE = 1'b1
	} plr_op_t;

	// Per-cycle commands from the line controller to each axis unit
	typedef struct packed {
		logic load;  // latch a new line, emit its first point
		logic step;  // advance the accumulators by one point
	} plr_ctl_t;

endpackage

@@ sv/plr_axis.sv @@
module plr_axis #(
	parameter int COORD_BITS = plr_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plr_pkg::plr_ctl_t             ctl,
	input  logic signed [COORD_BITS-1:0]  load_base,
	input  logic signed [COORD_BITS:0]    load_span,
	input  logic        [COORD_BITS-1:0]  len,
	output logic signed [COORD_BITS-1:0]  point
);
	import plr_pkg::*;

	localparam int SW = COORD_BITS + 2;
	localparam int WW = COORD_BITS + 3;

	logic signed [COORD_BITS-1:0] origin_q;
	logic signed [COORD_BITS:0]   span_q;
	logic signed [COORD_BITS:0]   quot_q;
	logic        [COORD_BITS-1:0] rem_q;

	logic signed [SW-1:0]         sum;
	logic signed [SW-1:0]         len_w;
	logic signed [SW-1:0]         sum_adj;
	logic signed [COORD_BITS:0]   quot_step;
	logic signed [COORD_BITS-1:0] base_sel;
	logic signed [COORD_BITS:0]   quot_sel;
	logic        [COORD_BITS-1:0] rem_sel;
	logic        [COORD_BITS:0]   two_r;
	logic                         half_ge;
	logic                         half_eq;
	logic signed [WW-1:0]         w_raw;
	logic signed [WW-1:0]         w_fix;

	// Exact remainder step: |span| <= len so one correction suffices
	always_comb begin
		len_w = $signed({2'b00, len});
		sum   = $signed({2'b00, rem_q}) + $signed({span_q[COORD_BITS], span_q});
		if (sum >= len_w) begin
			sum_adj   = sum - len_w;
			quot_step = quot_q + (COORD_BITS+1)'(1);
		end else if (sum < $signed(SW'(0))) begin
			sum_adj   = sum + len_w;
			quot_step = quot_q - (COORD_BITS+1)'(1);
		end else begin
			sum_adj   = sum;
			quot_step = quot_q;
		end
	end

	// A load rounds the new origin with zero quotient and remainder
	always_comb begin
		if (ctl.load) begin
			base_sel = load_base;
			quot_sel = '0;
			rem_sel  = '0;
		end else begin
			base_sel = origin_q;
			quot_sel = quot_step;
			rem_sel  = sum_adj[COORD_BITS-1:0];
		end
	end

	// Add one half, then truncate toward zero
	always_comb begin
		two_r   = {rem_sel, 1'b0};
		half_ge = two_r >= {1'b0, len};
		half_eq = two_r == {1'b0, len};
		w_raw   = $signed({{3{base_sel[COORD_BITS-1]}}, base_sel})
			+ $signed({{2{quot_sel[COORD_BITS]}}, quot_sel})
			+ $signed({{(WW-1){1'b0}}, half_ge});
		if (w_raw < $signed(WW'(0)) && !half_eq)
			w_fix = w_raw + WW'(1);
		else
			w_fix = w_raw;
	end

	assign point = w_fix[COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			span_q   <= '0;
			quot_q   <= '0;
			rem_q    <= '0;
		end else if (ctl.load) begin
			origin_q <= load_base;
			span_q   <= load_span;
			quot_q   <= '0;
			rem_q    <= '0;
		end else if (ctl.step) begin
			quot_q   <= quot_step;
			rem_q    <= sum_adj[COORD_BITS-1:0];
		end
	end

endmodule

@@ sv/parametric_line_rasterizer.sv @@
// Line rasterizer: walks the points of a straight line from endpoint B to A.
// Input channel (in_valid/in_ready): a word with operation = load latches
// both endpoints and a color and emits the point at B; operation = advance
// emits the next point of the active line. A line of length
// len = max(|dx|, |dy|) yields len+1 points; the point at A carries
// last_point. A line with A equal to B gives that single point. An advance
// with no active line is consumed and gives no word.
// Output channel (out_valid/out_ready): one point word per producing input.
// A word is taken into the input register; its point is then loaded into
// the output register when that register is free or being drained, and
// waits there until the receiver takes it. Throughput: one word per cycle
// while the receiver does not stall. Each point is one exact quotient and
// remainder update per axis (add, compare, correct) plus rounding, all in
// the single stage between the input and output registers.
// Reset (arst_n low) drops any line in progress and empties both registers.
// When the receiver stalls, the output word holds; the input register still
// takes one more word, then in_ready falls until the output drains.
module parametric_line_rasterizer #(
	parameter int COORD_BITS = plr_pkg::COORD_BITS_DEF,
	parameter int COLOR_BITS = plr_pkg::COLOR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic signed [COORD_BITS-1:0]  end_a_x,
	input  logic signed [COORD_BITS-1:0]  end_a_y,
	input  logic signed [COORD_BITS-1:0]  end_b_x,
	input  logic signed [COORD_BITS-1:0]  end_b_y,
	input  logic        [COLOR_BITS-1:0]  color_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS-1:0]  pixel_x,
	output logic signed [COORD_BITS-1:0]  pixel_y,
	output logic        [COLOR_BITS-1:0]  pixel_color,
	output logic                          last_point
);
	import plr_pkg::*;

	// Input register
	logic                         valid_s1;
	plr_op_t                      op_s1;
	logic signed [COORD_BITS-1:0] ax_s1;
	logic signed [COORD_BITS-1:0] ay_s1;
	logic signed [COORD_BITS-1:0] bx_s1;
	logic signed [COORD_BITS-1:0] by_s1;
	logic        [COLOR_BITS-1:0] color_s1;

	// Line state
	logic [COORD_BITS-1:0] len_q;
	logic [COORD_BITS-1:0] step_q;
	logic [COLOR_BITS-1:0] held_color_q;
	logic                  active_q;

	// Output register
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] pixel_x_q;
	logic signed [COORD_BITS-1:0] pixel_y_q;
	logic        [COLOR_BITS-1:0] pixel_color_q;
	logic                         last_q;

	logic                         advance;
	logic                         fire;
	logic                         is_load;
	plr_ctl_t                     ctl;
	logic signed [COORD_BITS:0]   dx;
	logic signed [COORD_BITS:0]   dy;
	logic [COORD_BITS-1:0]        abs_dx;
	logic [COORD_BITS-1:0]        abs_dy;
	logic [COORD_BITS-1:0]        len_ld;
	logic [COORD_BITS-1:0]        len_use;
	logic [COORD_BITS-1:0]        step_n;
	logic                         step_last;
	logic                         degenerate;
	logic                         emit;
	logic signed [COORD_BITS-1:0] pt_x;
	logic signed [COORD_BITS-1:0] pt_y;

	// The stage moves when the output register is free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;
	assign is_load  = op_s1 == OP_LOAD;

	// Span and length of a newly loaded line
	always_comb begin
		dx     = $signed({ax_s1[COORD_BITS-1], ax_s1}) - $signed({bx_s1[COORD_BITS-1], bx_s1});
		dy     = $signed({ay_s1[COORD_BITS-1], ay_s1}) - $signed({by_s1[COORD_BITS-1], by_s1});
		abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		len_ld = (abs_dx > abs_dy) ? abs_dx : abs_dy;
	end

	assign degenerate = len_ld == '0;
	assign len_use    = is_load ? len_ld : len_q;
	assign step_n     = step_q + COORD_BITS'(1);
	assign step_last  = step_n >= len_q;

	// Drop an advance that finds no active line
	assign ctl.load = fire && is_load;
	assign ctl.step = fire && !is_load && active_q;
	assign emit     = ctl.load || ctl.step;

	plr_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.load_base (bx_s1),
		.load_span (dx),
		.len       (len_use),
		.point     (pt_x)
	);

	plr_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.load_base (by_s1),
		.load_span (dy),
		.len       (len_use),
		.point     (pt_y)
	);

	// Input register: take a word whenever there is room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= plr_op_t'(operation);
			ax_s1    <= end_a_x;
			ay_s1    <= end_a_y;
			bx_s1    <= end_b_x;
			by_s1    <= end_b_y;
			color_s1 <= color_in;
		end
	end

	// Line state: a load restarts, a step counts toward the far endpoint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			step_q       <= '0;
			held_color_q <= '0;
			active_q     <= 1'b0;
		end else if (ctl.load) begin
			len_q        <= len_ld;
			step_q       <= '0;
			held_color_q <= color_s1;
			active_q     <= !degenerate;
		end else if (ctl.step) begin
			step_q       <= step_n;
			active_q     <= !step_last;
		end
	end

	// Output register: hold the word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			if (ctl.load) begin
				pixel_color_q <= color_s1;
				if (degenerate) begin
					// A single point: endpoint A exactly
					pixel_x_q <= ax_s1;
					pixel_y_q <= ay_s1;
					last_q    <= 1'b1;
				end else begin
					pixel_x_q <= pt_x;
					pixel_y_q <= pt_y;
					last_q    <= 1'b0;
				end
			end else begin
				pixel_color_q <= held_color_q;
				pixel_x_q     <= pt_x;
				pixel_y_q     <= pt_y;
				last_q        <= step_last;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign last_point  = last_q;

`ifndef SYNTHESIS
	a_active_len: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (len_q != '0))
		else $error("active line with zero length");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (step_q < len_q))
		else $error("step index reached line length while active");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && step_last) |=> !active_q)
		else $error("line still active after its last point");

	a_idle_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_load && !active_q) |=> ($stable(step_q) && !out_valid_q))
		else $error("advance without a line changed state or gave a word");
`endif

endmodule
